@@ src/cbc_pkg.sv @@
package cbc_pkg;

	// controller kinds; every other code banks nothing
	localparam logic [2:0] CT_NONE = 3'd0;
	localparam logic [2:0] CT_MBC1 = 3'd1;
	localparam logic [2:0] CT_MBC2 = 3'd2;
	localparam logic [2:0] CT_MBC3 = 3'd3;
	localparam logic [2:0] CT_MBC5 = 3'd5;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// register window picked by address bits 14:13
	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_BANK   = 2'd1;
	localparam logic [1:0] REG_RAM    = 2'd2;
	localparam logic [1:0] REG_MODE   = 2'd3;

	localparam int BANK_FIELD_W = 9;
	localparam int ROM_ADDR_W   = 24;
	localparam int BANK_SHIFT   = 14;
	localparam int BLOCK_SHIFT  = 19;

	localparam logic [7:0] CLK_MAP_LO = 8'h08;
	localparam logic [7:0] CLK_MAP_HI = 8'h0C;
	localparam logic [7:0] LATCH_CMD  = 8'h01;

	typedef struct packed {
		logic [1:0] upper_blk;
		logic [3:0] ram_win;
		logic       mode;
		logic [3:0] clock_map;
	} cbc_aux_t;

endpackage

@@ src/cbc_decode.sv @@
module cbc_decode #(
	parameter int ROM_BANK_BITS = 9
) (
	input  logic [2:0]               ctrl_type,
	input  logic                     operation,
	input  logic [14:0]              address,
	input  logic [7:0]               value,
	input  logic [ROM_BANK_BITS-1:0] bank_q,
	input  cbc_pkg::cbc_aux_t        aux_q,
	output logic [ROM_BANK_BITS-1:0] bank_d,
	output cbc_pkg::cbc_aux_t        aux_d,
	output logic [23:0]              rom_address,
	output logic                     clock_latch
);
	import cbc_pkg::*;

	logic [BANK_FIELD_W-1:0]  bank_ext;
	logic [BANK_FIELD_W-1:0]  bank_raw;
	logic [ROM_BANK_BITS-1:0] bank_masked;
	logic                     bank_wr;

	assign bank_ext    = BANK_FIELD_W'(bank_q);
	assign bank_masked = bank_raw[ROM_BANK_BITS-1:0];

	always_comb begin
		aux_d       = aux_q;
		bank_wr     = 1'b0;
		bank_raw    = '0;
		clock_latch = 1'b0;
		if (operation == OP_WRITE && address[14:13] != REG_ENABLE) begin
			case (ctrl_type)
				CT_MBC1: begin
					case (address[14:13])
						REG_BANK: begin
							bank_wr  = 1'b1;
							bank_raw = BANK_FIELD_W'(value[4:0]);
						end
						REG_RAM: begin
							if (aux_q.mode) begin
								aux_d.ram_win = {2'b00, value[1:0]};
							end else begin
								aux_d.upper_blk = value[1:0];
							end
						end
						default: begin
							if (value[0]) begin
								aux_d.mode = 1'b1;
								bank_wr    = 1'b1;
								bank_raw   = BANK_FIELD_W'(bank_ext[4:0]);
							end else begin
								aux_d.mode    = 1'b0;
								aux_d.ram_win = '0;
							end
						end
					endcase
				end
				CT_MBC2: begin
					if (address[14:13] == REG_BANK) begin
						bank_wr  = 1'b1;
						bank_raw = BANK_FIELD_W'(value[3:0]);
					end
				end
				CT_MBC3: begin
					case (address[14:13])
						REG_BANK: begin
							bank_wr  = 1'b1;
							bank_raw = BANK_FIELD_W'(value[6:0]);
						end
						REG_RAM: begin
							if (value inside {[CLK_MAP_LO:CLK_MAP_HI]}) begin
								aux_d.clock_map = value[3:0];
							end else begin
								aux_d.ram_win   = {2'b00, value[1:0]};
								aux_d.clock_map = '0;
							end
						end
						default: begin
							clock_latch = (value == LATCH_CMD);
						end
					endcase
				end
				CT_MBC5: begin
					case (address[14:13])
						REG_BANK: begin
							bank_wr = 1'b1;
							// low half sets bits 7:0, upper half sets bit 8
							if (!address[12]) begin
								bank_raw = {bank_ext[8], value};
							end else begin
								bank_raw = {value[0], bank_ext[7:0]};
							end
						end
						REG_RAM: begin
							aux_d.ram_win = value[3:0];
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		bank_d = bank_q;
		if (bank_wr) begin
			bank_d = (bank_masked == '0) ? ROM_BANK_BITS'(1) : bank_masked;
		end
	end

	always_comb begin
		rom_address = '0;
		if (operation == OP_READ) begin
			if (!address[14]) begin
				rom_address = ROM_ADDR_W'(address);
			end else begin
				rom_address = (ROM_ADDR_W'(bank_q) << BANK_SHIFT)
					+ (ROM_ADDR_W'(aux_q.upper_blk) << BLOCK_SHIFT)
					+ ROM_ADDR_W'(address[13:0]);
			end
		end
	end

endmodule

@@ src/cartridge_bank_controller_top.sv @@
// cartridge bank controller
// each input item is one bus access to the 32 KiB ROM area: operation 0 is a
// read, which comes back as the physical ROM byte address; operation 1 is a
// write to the banking registers, decoded by the configured controller type.
// every item gives exactly one result item carrying the ROM address (zero for
// writes), the RAM window bank and clock register map after the access, and
// the clock latch request.
// cfg_wr_en / cfg_wr_data set the controller type; write it only while idle.
// an item passes from the input register through the decode into the result
// register. throughput: one item per cycle while the receiver does not stall;
// the banking state updates as an item moves to the result register, so the
// following item already sees it.
// when the receiver stalls, the result holds and the input register still
// takes one more item; in_ready drops once both registers are full.
// reset clears the type to none, the ROM bank to one and all other banking
// state to zero; both pipeline registers come up empty.
module cartridge_bank_controller_top #(
	parameter int ROM_BANK_BITS = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [14:0] address,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] rom_address,
	output logic [3:0]  ram_window_bank,
	output logic [3:0]  clock_map,
	output logic        clock_latch
);
	import cbc_pkg::*;

	logic [2:0]               ctrl_type_q;
	logic [ROM_BANK_BITS-1:0] bank_q;
	logic [ROM_BANK_BITS-1:0] bank_d;
	cbc_aux_t                 aux_q;
	cbc_aux_t                 aux_d;

	logic        valid_s1;
	logic        op_s1;
	logic [14:0] addr_s1;
	logic [7:0]  value_s1;

	logic        valid_s2;
	logic [23:0] rom_address_s2;
	logic [3:0]  ram_win_s2;
	logic [3:0]  clock_map_s2;
	logic        latch_s2;

	logic [23:0] rom_address_d;
	logic        latch_d;
	logic        s2_free;
	logic        s1_adv;

	assign s2_free  = !valid_s2 || out_ready;
	assign s1_adv   = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_type_q <= CT_NONE;
		end else if (cfg_wr_en) begin
			ctrl_type_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= operation;
			addr_s1  <= address;
			value_s1 <= value;
		end
	end

	cbc_decode #(
		.ROM_BANK_BITS(ROM_BANK_BITS)
	) u_decode (
		.ctrl_type   (ctrl_type_q),
		.operation   (op_s1),
		.address     (addr_s1),
		.value       (value_s1),
		.bank_q      (bank_q),
		.aux_q       (aux_q),
		.bank_d      (bank_d),
		.aux_d       (aux_d),
		.rom_address (rom_address_d),
		.clock_latch (latch_d)
	);

	// banking state commits with the item that changed it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= ROM_BANK_BITS'(1);
			aux_q  <= '0;
		end else if (s1_adv) begin
			bank_q <= bank_d;
			aux_q  <= aux_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rom_address_s2 <= rom_address_d;
			ram_win_s2     <= aux_d.ram_win;
			clock_map_s2   <= aux_d.clock_map;
			latch_s2       <= latch_d;
		end
	end

	assign out_valid       = valid_s2;
	assign rom_address     = rom_address_s2;
	assign ram_window_bank = ram_win_s2;
	assign clock_map       = clock_map_s2;
	assign clock_latch     = latch_s2;

	a_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		bank_q != '0)
		else $error("rom bank register holds zero");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(bank_q) && $stable(aux_q))
		else $error("banking state changed without an item");

	a_clock_map_range: assert property (@(posedge clk) disable iff (!arst_n)
		aux_q.clock_map == 4'd0 || (aux_q.clock_map >= 4'd8 && aux_q.clock_map <= 4'd12))
		else $error("clock map out of range");

	a_latch_source: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && latch_d |-> op_s1 == OP_WRITE && ctrl_type_q == CT_MBC3)
		else $error("clock latch outside a type-3 write");

	a_write_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && op_s1 == OP_WRITE |=> rom_address_s2 == '0)
		else $error("write item produced a rom address");

endmodule
